>>> rtl/udec_pkg.sv
// Shared types and constants for the unsigned-to-decimal ASCII converter.
// No dependencies; used by udec_cell, udec_ctrl and unsigned_to_decimal_ascii.
`default_nettype none

package udec_pkg;

   localparam int VALUE_W            = 32;
   localparam int BIT_CNT_W          = $clog2(VALUE_W);
   localparam int BCD_W              = 4;
   localparam int DIGIT_CHAR_W       = 6;
   localparam int MAX_DIGITS_DEFAULT = 10;

   localparam logic [DIGIT_CHAR_W-1:0] ASCII_ZERO      = 6'd48;
   localparam logic [BCD_W-1:0]        DABBLE_LIMIT    = 4'd5;
   localparam logic [BCD_W-1:0]        DABBLE_ADJUST   = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SKIP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic advance;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> rtl/udec_cell.sv
// One decimal digit cell of the converter chain: add-3 correction and shift
// during conversion, digit hand-off toward the top during output.
// Depends on udec_pkg.
`default_nettype none

module udec_cell (
   input  wire logic                        clock,
   input  wire udec_pkg::cell_ctrl_type     ctrl,
   input  wire logic                        carry_in,
   input  wire logic [udec_pkg::BCD_W-1:0]  digit_in,
   output logic                             carry_out,
   output logic      [udec_pkg::BCD_W-1:0]  digit
);

   import udec_pkg::*;

   logic [BCD_W-1:0] digit_ff;
   logic [BCD_W-1:0] digit_in_next;
   logic [BCD_W-1:0] adjusted;

   always_comb begin
      adjusted = (digit_ff >= DABBLE_LIMIT) ? digit_ff + DABBLE_ADJUST : digit_ff;
   end

   assign carry_out = adjusted[BCD_W-1];
   assign digit     = digit_ff;

   always_comb begin
      digit_in_next = digit_ff;
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adjusted[BCD_W-2:0], carry_in};
      end else if (ctrl.advance) begin
         digit_in_next = digit_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule

`default_nettype wire

>>> rtl/udec_ctrl.sv
// Sequencer for the converter: feeds value bits into the digit chain, skips
// leading zeros and paces the digits out. Depends on udec_pkg.
`default_nettype none

module udec_ctrl #(
   parameter int MAX_DIGITS = udec_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [udec_pkg::VALUE_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_last,
   input  wire logic                          top_zero,
   input  wire logic                          top_carry,
   output udec_pkg::cell_ctrl_type            cell_ctrl,
   output logic                               serial_bit
);

   import udec_pkg::*;

   localparam int REM_W = $clog2(MAX_DIGITS + 1);

   state_type                state_ff, state_in;
   logic [VALUE_W-1:0]       value_ff, value_in;
   logic [BIT_CNT_W-1:0]     bit_cnt_ff, bit_cnt_in;
   logic [REM_W-1:0]         remaining_ff, remaining_in;
   logic                     sticky_ff, sticky_in;
   logic                     bits_done;
   logic                     skip_more;

   assign bits_done  = (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1));
   assign skip_more  = !sticky_ff && top_zero && (remaining_ff > REM_W'(1));
   assign serial_bit = value_ff[VALUE_W-1];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bits_done) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_more) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready && rsp_last) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready         = 1'b0;
      rsp_valid         = 1'b0;
      rsp_last          = 1'b0;
      cell_ctrl.clear   = 1'b0;
      cell_ctrl.dabble  = 1'b0;
      cell_ctrl.advance = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            cell_ctrl.clear = req_valid;
         end
         ST_CONVERT: begin
            cell_ctrl.dabble = 1'b1;
         end
         ST_SKIP: begin
            cell_ctrl.advance = skip_more;
         end
         ST_EMIT: begin
            rsp_valid         = 1'b1;
            rsp_last          = (remaining_ff == REM_W'(1));
            cell_ctrl.advance = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      value_in     = value_ff;
      bit_cnt_in   = bit_cnt_ff;
      remaining_in = remaining_ff;
      sticky_in    = sticky_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in   = req_value;
               bit_cnt_in = '0;
               sticky_in  = 1'b0;
            end
         end
         ST_CONVERT: begin
            value_in   = {value_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            sticky_in  = sticky_ff | top_carry;
            if (bits_done) remaining_in = REM_W'(MAX_DIGITS);
         end
         ST_SKIP: begin
            if (skip_more) remaining_in = remaining_ff - REM_W'(1);
         end
         ST_EMIT: begin
            if (rsp_ready) remaining_in = remaining_ff - REM_W'(1);
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         bit_cnt_ff   <= '0;
         sticky_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         bit_cnt_ff   <= bit_cnt_in;
         sticky_ff    <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CONVERT) && (bit_cnt_ff == '0))
      else $error("accepted item did not start conversion");

   a_emit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (remaining_ff != '0) && (remaining_ff <= REM_W'(MAX_DIGITS)))
      else $error("digit count out of range while emitting");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("block not free after last digit");

   a_cell_ctrl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cell_ctrl.clear, cell_ctrl.dabble, cell_ctrl.advance}))
      else $error("conflicting cell controls");

   a_convert_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONVERT && bits_done) |=> (state_ff == ST_SKIP)
         && (remaining_ff == REM_W'(MAX_DIGITS)))
      else $error("conversion did not hand over to digit output");

endmodule

`default_nettype wire

>>> rtl/unsigned_to_decimal_ascii.sv
// Top level of the unsigned-to-decimal ASCII converter: sequencer plus a chain
// of MAX_DIGITS digit cells. Depends on udec_pkg, udec_cell and udec_ctrl.
//
//   channel | ports                               | dir | moves
//   req     | req_valid req_ready req_value       | in  | one 32-bit value per item
//   rsp     | rsp_valid rsp_ready rsp_digit_char  | out | one ASCII digit per item,
//           | rsp_last                            |     | most significant first
//
// An accepted value enters the digit chain one value bit per cycle, then leading
// zeros are dropped one per cycle, then one digit leaves per cycle while rsp_ready
// is high. Leading zeros and digits add up to MAX_DIGITS.
// A new value is taken only in the idle cycle after the last digit leaves.
// Reset returns the sequencer to idle; cells are cleared when a value is taken.
`default_nettype none

module unsigned_to_decimal_ascii #(
   parameter int MAX_DIGITS = udec_pkg::MAX_DIGITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [udec_pkg::VALUE_W-1:0]       req_value,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic      [udec_pkg::DIGIT_CHAR_W-1:0]  rsp_digit_char,
   output logic                                    rsp_last
);

   import udec_pkg::*;

   cell_ctrl_type    cell_ctrl;
   logic             serial_bit;
   logic [BCD_W-1:0] digits [MAX_DIGITS];
   logic             carries [MAX_DIGITS];

   udec_ctrl #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_last   (rsp_last),
      .top_zero   (digits[MAX_DIGITS-1] == '0),
      .top_carry  (carries[MAX_DIGITS-1]),
      .cell_ctrl  (cell_ctrl),
      .serial_bit (serial_bit)
   );

   for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_first
         udec_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .carry_in  (serial_bit),
            .digit_in  ('0),
            .carry_out (carries[i]),
            .digit     (digits[i])
         );
      end else begin : g_rest
         udec_cell u_cell (
            .clock     (clock),
            .ctrl      (cell_ctrl),
            .carry_in  (carries[i-1]),
            .digit_in  (digits[i-1]),
            .carry_out (carries[i]),
            .digit     (digits[i])
         );
      end
   end

   assign rsp_digit_char = ASCII_ZERO + {{(DIGIT_CHAR_W-BCD_W){1'b0}}, digits[MAX_DIGITS-1]};

endmodule

`default_nettype wire

>>> bench/unsigned_to_decimal_ascii_test.sv
`timescale 1ns / 1ps
// Self-checking bench for unsigned_to_decimal_ascii: random and directed values in, digits out.
// A scoreboard predicts the expected digits and checks each one against the block's output.
// Depends on udec_pkg and the unsigned_to_decimal_ascii RTL.

module unsigned_to_decimal_ascii_test;

   localparam int DIGIT_DEPTH = udec_pkg::MAX_DIGITS_DEFAULT;

   typedef struct packed {
      logic [udec_pkg::DIGIT_CHAR_W-1:0] ch;
      logic                              last;
   } digit_type;

   class digit_scoreboard;
      digit_type expected_digits[$];
      int        error_count;
      int        values_seen;
      int        ten_digit_values;
      int        digits_checked;

      function new();
         error_count      = 0;
         values_seen      = 0;
         ten_digit_values = 0;
         digits_checked   = 0;
      endfunction

      function void note_value(input logic [udec_pkg::VALUE_W-1:0] value);
         logic [3:0]                  decimal [DIGIT_DEPTH];
         logic [udec_pkg::VALUE_W-1:0] rest;
         int                          count;
         digit_type                   d;
         rest  = value;
         count = 0;
         do begin
            decimal[count] = 4'(rest % 10);
            rest           = rest / 10;
            count++;
         end while (rest != 0 && count < DIGIT_DEPTH);
         for (int k = count - 1; k >= 0; k--) begin
            d.ch   = udec_pkg::ASCII_ZERO + udec_pkg::DIGIT_CHAR_W'(decimal[k]);
            d.last = (k == 0);
            expected_digits.push_back(d);
         end
         values_seen++;
         if (count == 10) begin
            ten_digit_values++;
         end
      endfunction

      function void check_digit(input logic [udec_pkg::DIGIT_CHAR_W-1:0] ch, input logic last);
         digit_type want;
         if (expected_digits.size() == 0) begin
            $display("%0t: unexpected digit, got char %0d last %0b", $time, ch, last);
            error_count++;
            return;
         end
         want = expected_digits.pop_front();
         digits_checked++;
         if (ch !== want.ch) begin
            $display("%0t: digit_char mismatch, expected %0d, got %0d", $time, want.ch, ch);
            error_count++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, last);
            error_count++;
         end
      endfunction

      function int pending_digits();
         return expected_digits.size();
      endfunction
   endclass

   logic                                clock;
   logic                                reset;
   logic                                req_valid;
   logic                                req_ready;
   logic [udec_pkg::VALUE_W-1:0]        req_value;
   logic                                rsp_valid;
   logic                                rsp_ready;
   logic [udec_pkg::DIGIT_CHAR_W-1:0]   rsp_digit_char;
   logic                                rsp_last;

   digit_scoreboard sb;
   int              req_gap_max;
   int              rsp_stall_max;
   int              rsp_hold_cycles;

   unsigned_to_decimal_ascii #(
      .MAX_DIGITS(DIGIT_DEPTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_value(req_value);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_digit(rsp_digit_char, rsp_last);
      end
   end

   // hold valid high across back-to-back items
   task automatic send_value(input logic [udec_pkg::VALUE_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_digits();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_digits() != 0);
   endtask

   function automatic logic [udec_pkg::VALUE_W-1:0] random_value();
      longint unsigned lo;
      longint unsigned hi;
      int              n;
      int              pick;
      n  = $urandom_range(1, 10);
      lo = 1;
      repeat (n - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (n == 1) begin
         lo = 0;
      end
      if (hi > 64'hFFFF_FFFF) begin
         hi = 64'hFFFF_FFFF;
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         return $urandom;
      end
      if (pick == 1) begin
         return 32'(hi);
      end
      if (pick == 2) begin
         return 32'(lo);
      end
      return 32'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
   endfunction

   initial begin
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         int stall;
         if (rsp_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #6_000_000;
      $display("unsigned_to_decimal_ascii_test: errors");
      $finish;
   end

   initial begin
      logic [udec_pkg::VALUE_W-1:0] directed_values[$];
      sb              = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      rsp_ready       = 1'b0;
      req_gap_max     = 0;
      rsp_stall_max   = 0;
      rsp_hold_cycles = 0;
      directed_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd999,
                          32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000, 32'd999999,
                          32'd1000000, 32'd9999999, 32'd10000000, 32'd99999999,
                          32'd100000000, 32'd999999999, 32'd1000000000, 32'd1234567890,
                          32'h8000_0000, 32'hFFFF_FFFE, 32'hFFFF_FFFF};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_values[i]) begin
         send_value(directed_values[i]);
      end

      req_gap_max   = 17;
      rsp_stall_max = 17;
      repeat (120) send_value(random_value());
      drain_digits();

      req_gap_max   = 0;
      rsp_stall_max = 0;
      repeat (60) send_value(random_value());

      // stall the output long enough to back up the input
      req_gap_max     = 3;
      rsp_hold_cycles = 400;
      repeat (40) send_value(random_value());

      req_gap_max   = 0;
      rsp_stall_max = 17;
      repeat (20) send_value(random_value());

      req_gap_max   = 17;
      rsp_stall_max = 17;
      repeat (110) send_value(random_value());

      drain_digits();
      repeat (60) @(posedge clock);

      $display("Converted %0d values (%0d with ten digits) and checked %0d digits,",
               sb.values_seen, sb.ten_digit_values, sb.digits_checked);
      $display("under random gaps, back-to-back traffic and a long output stall.");
      if (sb.error_count == 0 && sb.pending_digits() == 0) begin
         $display("unsigned_to_decimal_ascii_test: clean");
      end else begin
         $display("unsigned_to_decimal_ascii_test: errors");
      end
      $finish;
   end

endmodule
